### design/cbsp_pkg.sv
// Package for the cartridge bank switch planner: payload structs, mapper kinds,
// command and register codes, and mapper register addresses.
// No dependencies.
package cbsp_pkg;

  typedef struct packed {
    logic [1:0] cmd;
    logic [8:0] bank;
  } cmd_t;

  typedef struct packed {
    logic        has_write;
    logic [15:0] write_address;
    logic [7:0]  write_value;
    logic [15:0] window_address;
    logic        ok;
    logic        last;
  } res_t;

  // One planned mapper register write
  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  val;
  } wr_t;

  // Per-command summary carried beside the write list
  typedef struct packed {
    logic        ok;
    logic [15:0] window;
  } plan_hdr_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ROM,
    KIND_MBC1,
    KIND_MBC2,
    KIND_MBC3,
    KIND_MBC5,
    KIND_HUC1
  } kind_e;

  localparam logic [1:0] CMD_ROM_BANK = 2'd0;
  localparam logic [1:0] CMD_RAM_EN   = 2'd1;
  localparam logic [1:0] CMD_RAM_BANK = 2'd2;
  localparam logic [1:0] CMD_RESTORE  = 2'd3;

  localparam logic REG_CART_TYPE  = 1'b0;
  localparam logic REG_LARGE_MBC3 = 1'b1;

  localparam logic [15:0] ADDR_RAMG   = 16'h0000;
  localparam logic [15:0] ADDR_ROMB   = 16'h2000;
  localparam logic [15:0] ADDR_MBC2   = 16'h2100;
  localparam logic [15:0] ADDR_ROMB_HI = 16'h3000;
  localparam logic [15:0] ADDR_RAMB   = 16'h4000;
  localparam logic [15:0] ADDR_MODE   = 16'h6000;
  localparam logic [15:0] ADDR_EXT    = 16'ha000;

  localparam logic [15:0] WIN_LOW  = 16'h0000;
  localparam logic [15:0] WIN_HIGH = 16'h4000;
  localparam logic [15:0] WIN_RAM  = 16'ha000;

  localparam logic [7:0] VAL_RAM_ON  = 8'h0a;
  localparam logic [7:0] VAL_HUC1_IR = 8'h0e;

endpackage

### design/cbsp_front.sv
// Front end of the planner: takes command beats, decodes the cartridge type
// and turns each command into a write plan. Depends on cbsp_pkg.
module cbsp_front #(
  parameter int MAX_WRITES = 4,
  parameter int CntW       = 3
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cbsp_pkg::cmd_t       in_data_i,
  input  logic [7:0]           cart_type_i,
  input  logic                 large_mbc3_i,
  input  logic                 q_ready_i,
  output logic                 push_o,
  output cbsp_pkg::plan_hdr_t  hdr_o,
  output logic [CntW-1:0]      cnt_o,
  output cbsp_pkg::wr_t        wr_o [MAX_WRITES]
);
  import cbsp_pkg::*;

  kind_e      kind;
  logic       ram;
  logic       rumble;
  logic       ok;
  logic [15:0] win;
  logic [CntW-1:0] n;
  logic [8:0] b;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i & q_ready_i;
  assign b          = in_data_i.bank;

  always_comb begin
    kind   = KIND_NONE;
    ram    = 1'b0;
    rumble = 1'b0;
    unique case (cart_type_i) inside
      8'h00:               kind = KIND_ROM;
      8'h08, 8'h09:        begin kind = KIND_ROM;  ram = 1'b1; end
      8'h01:               kind = KIND_MBC1;
      8'h02, 8'h03:        begin kind = KIND_MBC1; ram = 1'b1; end
      8'h05, 8'h06:        begin kind = KIND_MBC2; ram = 1'b1; end
      8'h0f, 8'h11:        kind = KIND_MBC3;
      8'h10, 8'h12, 8'h13: begin kind = KIND_MBC3; ram = 1'b1; end
      8'h19:               kind = KIND_MBC5;
      8'h1a, 8'h1b:        begin kind = KIND_MBC5; ram = 1'b1; end
      8'h1c:               begin kind = KIND_MBC5; rumble = 1'b1; end
      8'h1d, 8'h1e:        begin kind = KIND_MBC5; ram = 1'b1; rumble = 1'b1; end
      8'hff:               begin kind = KIND_HUC1; ram = 1'b1; end
      default:             kind = KIND_NONE;
    endcase
  end

  always_comb begin
    ok  = 1'b0;
    win = WIN_LOW;
    n   = '0;
    for (int i = 0; i < MAX_WRITES; i++) begin
      wr_o[i] = '0;
    end
    case (in_data_i.cmd)
      CMD_ROM_BANK: begin
        win = (b == 9'd0) ? WIN_LOW : WIN_HIGH;
        case (kind)
          KIND_ROM: ok = (b <= 9'd1);
          KIND_MBC1: begin
            ok = (b <= 9'h7f);
            if (b == 9'd0) begin
              wr_o[0] = '{ADDR_MODE, 8'd0};
              wr_o[1] = '{ADDR_RAMB, 8'd0};
              wr_o[2] = '{ADDR_ROMB, 8'd1};
              n = CntW'(3);
            end else if (b[4:0] == 5'd0) begin
              // Banks 0x20/0x40/0x60 only show in the low window in mode 1
              win = WIN_LOW;
              wr_o[0] = '{ADDR_MODE, 8'd1};
              wr_o[1] = '{ADDR_RAMB, {6'd0, b[6:5]}};
              n = CntW'(2);
            end else begin
              wr_o[0] = '{ADDR_MODE, 8'd0};
              wr_o[1] = '{ADDR_RAMB, {6'd0, b[6:5]}};
              wr_o[2] = '{ADDR_ROMB, {3'd0, b[4:0]}};
              n = CntW'(3);
            end
          end
          KIND_MBC2: begin
            ok = (b <= 9'h0f);
            wr_o[0] = '{ADDR_MBC2, {4'd0, b[3:0]}};
            n = (b != 9'd0) ? CntW'(1) : '0;
          end
          KIND_MBC3: begin
            ok = (b <= (large_mbc3_i ? 9'hff : 9'h7f));
            wr_o[0] = '{ADDR_ROMB, b[7:0]};
            n = (b != 9'd0) ? CntW'(1) : '0;
          end
          KIND_MBC5: begin
            ok = 1'b1;
            wr_o[0] = '{ADDR_ROMB, b[7:0]};
            wr_o[1] = '{ADDR_ROMB_HI, {7'd0, b[8]}};
            n = (b != 9'd0) ? CntW'(2) : '0;
          end
          KIND_HUC1: begin
            ok = (b <= 9'h3f);
            wr_o[0] = '{ADDR_ROMB, b[7:0]};
            n = (b != 9'd0) ? CntW'(1) : '0;
          end
          default: ok = 1'b0;
        endcase
      end
      CMD_RAM_EN: begin
        win = WIN_RAM;
        ok  = ram & (kind != KIND_NONE);
        wr_o[0] = '{ADDR_RAMG, VAL_RAM_ON};
        n = (kind != KIND_ROM) ? CntW'(1) : '0;
      end
      CMD_RAM_BANK: begin
        win = WIN_RAM;
        case (kind)
          KIND_ROM, KIND_MBC2: ok = ram & (b == 9'd0);
          KIND_MBC1: begin
            ok = ram & (b <= 9'd3);
            wr_o[0] = '{ADDR_MODE, 8'd1};
            wr_o[1] = '{ADDR_RAMB, b[7:0]};
            n = CntW'(2);
          end
          KIND_MBC3: begin
            ok = ram & (b <= (large_mbc3_i ? 9'd7 : 9'd3));
            wr_o[0] = '{ADDR_RAMB, b[7:0]};
            n = CntW'(1);
          end
          KIND_HUC1: begin
            ok = ram & (b <= 9'd3);
            wr_o[0] = '{ADDR_RAMB, b[7:0]};
            n = CntW'(1);
          end
          KIND_MBC5: begin
            ok = ram & (b <= (rumble ? 9'd7 : 9'd15));
            wr_o[0] = '{ADDR_RAMB, {4'd0, b[3:0]}};
            n = CntW'(1);
          end
          default: ok = 1'b0;
        endcase
      end
      default: begin
        win = WIN_LOW;
        case (kind)
          KIND_ROM: ok = 1'b1;
          KIND_MBC1: begin
            ok = 1'b1;
            wr_o[0] = '{ADDR_RAMG, 8'd0};
            wr_o[1] = '{ADDR_MODE, 8'd0};
            wr_o[2] = '{ADDR_RAMB, 8'd0};
            wr_o[3] = '{ADDR_ROMB, 8'd1};
            n = CntW'(4);
          end
          KIND_MBC2: begin
            ok = 1'b1;
            wr_o[0] = '{ADDR_RAMG, 8'd0};
            wr_o[1] = '{ADDR_MBC2, 8'd1};
            n = CntW'(2);
          end
          KIND_MBC3: begin
            ok = 1'b1;
            wr_o[0] = '{ADDR_RAMG, 8'd0};
            wr_o[1] = '{ADDR_RAMB, 8'd0};
            wr_o[2] = '{ADDR_ROMB, 8'd1};
            n = CntW'(3);
          end
          KIND_MBC5: begin
            ok = 1'b1;
            wr_o[0] = '{ADDR_RAMG, 8'd0};
            wr_o[1] = '{ADDR_RAMB, 8'd0};
            wr_o[2] = '{ADDR_ROMB_HI, 8'd0};
            wr_o[3] = '{ADDR_ROMB, 8'd1};
            n = CntW'(4);
          end
          KIND_HUC1: begin
            ok = 1'b1;
            wr_o[0] = '{ADDR_RAMG, VAL_HUC1_IR};
            wr_o[1] = '{ADDR_EXT, 8'd0};
            wr_o[2] = '{ADDR_RAMB, 8'd0};
            wr_o[3] = '{ADDR_ROMB, 8'd1};
            n = CntW'(4);
          end
          default: ok = 1'b0;
        endcase
      end
    endcase
    // Failed command: single empty beat with zeroed window
    if (!ok) begin
      win = WIN_LOW;
      n   = '0;
    end
  end

  assign hdr_o = '{ok, win};
  assign cnt_o = n;

endmodule

### design/cbsp_queue.sv
// Two-entry plan queue between front and back end.
// Depends on cbsp_pkg.
module cbsp_queue #(
  parameter int MAX_WRITES = 4,
  parameter int CntW       = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                ready_o,
  input  cbsp_pkg::plan_hdr_t hdr_i,
  input  logic [CntW-1:0]     cnt_i,
  input  cbsp_pkg::wr_t       wr_i [MAX_WRITES],
  input  logic                pop_i,
  output logic                valid_o,
  output cbsp_pkg::plan_hdr_t hdr_o,
  output logic [CntW-1:0]     cnt_o,
  output cbsp_pkg::wr_t       wr_o [MAX_WRITES]
);
  import cbsp_pkg::*;

  plan_hdr_t       hdr_q [2];
  logic [CntW-1:0] cnt_q [2];
  wr_t             wr_q  [2][MAX_WRITES];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      fill_q, fill_d;
  logic            do_push, do_pop;

  assign ready_o = (fill_q != 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  assign hdr_o = hdr_q[rptr_q];
  assign cnt_o = cnt_q[rptr_q];
  always_comb begin
    for (int i = 0; i < MAX_WRITES; i++) begin
      wr_o[i] = wr_q[rptr_q][i];
    end
  end

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    fill_d = fill_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      hdr_q[wptr_q] <= hdr_i;
      cnt_q[wptr_q] <= cnt_i;
      for (int i = 0; i < MAX_WRITES; i++) begin
        wr_q[wptr_q][i] <= wr_i[i];
      end
    end
  end

endmodule

### design/cbsp_back.sv
// Back end of the planner: steps through one plan a beat at a time and
// drives the registered result channel. Depends on cbsp_pkg.
module cbsp_back #(
  parameter int MAX_WRITES = 4,
  parameter int CntW       = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                pop_o,
  input  cbsp_pkg::plan_hdr_t hdr_i,
  input  logic [CntW-1:0]     cnt_i,
  input  cbsp_pkg::wr_t       wr_i [MAX_WRITES],
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cbsp_pkg::res_t      out_data_o
);
  import cbsp_pkg::*;

  localparam int IdxW = CntW - 1;

  plan_hdr_t       hdr_q;
  logic [CntW-1:0] cnt_q;
  wr_t             wr_q [MAX_WRITES];
  logic            cur_valid_q, cur_valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  res_t            out_q;
  res_t            res;
  logic            load;
  logic            is_last;
  logic            has_wr;

  assign has_wr  = (cnt_q != '0);
  assign is_last = !has_wr || (({1'b0, idx_q} + CntW'(1)) == cnt_q);
  assign load    = cur_valid_q & (~out_valid_q | out_ready_i);
  // Refill the current plan when empty or when its last beat goes out now
  assign pop_o   = q_valid_i & (~cur_valid_q | (load & is_last));

  always_comb begin
    res.has_write      = has_wr;
    res.write_address  = has_wr ? wr_q[idx_q].addr : '0;
    res.write_value    = has_wr ? wr_q[idx_q].val : '0;
    res.window_address = hdr_q.window;
    res.ok             = hdr_q.ok;
    res.last           = is_last;
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (load) begin
      idx_d = idx_q + IdxW'(1);
      if (is_last) begin
        cur_valid_d = 1'b0;
      end
    end
    if (pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hdr_q <= hdr_i;
      cnt_q <= cnt_i;
      for (int i = 0; i < MAX_WRITES; i++) begin
        wr_q[i] <= wr_i[i];
      end
    end
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/cart_bank_switch_planner.sv
// Cartridge bank switch planner, top level: config registers, front, queue, back.
// A plan passes the queue entry, the back end's plan register and the output register in turn.
// Throughput: one result beat per cycle from the back-end sequencer while out_ready_i does
// not hold the output; a command of N writes (0 to 4) gives max(N, 1) result beats (1 to 4).
// Commands are taken every cycle while the two-entry plan queue has room.
// Reset (rst_ni low, asynchronous) empties queue and output; cart_type and large_mbc3 clear to 0.
// Depends on cbsp_pkg, cbsp_front, cbsp_queue, cbsp_back.
module cart_bank_switch_planner #(
  parameter int MAX_WRITES = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cbsp_pkg::cmd_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cbsp_pkg::res_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import cbsp_pkg::*;

  // Beat index needs clog2(MAX_WRITES) bits; counts need one more
  localparam int CntW = $clog2(MAX_WRITES) + 1;

  logic [7:0]      cart_type_q, cart_type_d;
  logic            large_mbc3_q, large_mbc3_d;
  logic            cfg_wr;

  logic            push;
  logic            q_ready;
  plan_hdr_t       f_hdr;
  logic [CntW-1:0] f_cnt;
  wr_t             f_wr [MAX_WRITES];

  logic            q_valid;
  logic            pop;
  plan_hdr_t       q_hdr;
  logic [CntW-1:0] q_cnt;
  wr_t             q_wr [MAX_WRITES];

  // Configuration port: pready is always high, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    cart_type_d  = cart_type_q;
    large_mbc3_d = large_mbc3_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_CART_TYPE:  cart_type_d  = pwdata[7:0];
        REG_LARGE_MBC3: large_mbc3_d = pwdata[0];
        default:        cart_type_d  = cart_type_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CART_TYPE:  prdata = {24'd0, cart_type_q};
      REG_LARGE_MBC3: prdata = {31'd0, large_mbc3_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_type_q  <= 8'd0;
      large_mbc3_q <= 1'b0;
    end else begin
      cart_type_q  <= cart_type_d;
      large_mbc3_q <= large_mbc3_d;
    end
  end

  // Front: classify the command beat and build its write plan
  cbsp_front #(
    .MAX_WRITES (MAX_WRITES),
    .CntW       (CntW)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cart_type_i  (cart_type_q),
    .large_mbc3_i (large_mbc3_q),
    .q_ready_i    (q_ready),
    .push_o       (push),
    .hdr_o        (f_hdr),
    .cnt_o        (f_cnt),
    .wr_o         (f_wr)
  );

  // Hold up to two plans so the front keeps taking beats while the back drains
  cbsp_queue #(
    .MAX_WRITES (MAX_WRITES),
    .CntW       (CntW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .hdr_i   (f_hdr),
    .cnt_i   (f_cnt),
    .wr_i    (f_wr),
    .pop_i   (pop),
    .valid_o (q_valid),
    .hdr_o   (q_hdr),
    .cnt_o   (q_cnt),
    .wr_o    (q_wr)
  );

  // Back: advance through the plan, one result beat per cycle while out_ready_i does not hold the output
  cbsp_back #(
    .MAX_WRITES (MAX_WRITES),
    .CntW       (CntW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .pop_o       (pop),
    .hdr_i       (q_hdr),
    .cnt_i       (q_cnt),
    .wr_i        (q_wr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
